>>> rtl/wsncc_pkg.sv
// Shared constants and the pipeline word type for the window-sum NCC block.
package wsncc_pkg;

  localparam int FRAC_BITS = 15;
  localparam int Q_BITS    = 16;
  localparam int VAR_BITS  = 53;
  localparam int PROD_BITS = 2 * VAR_BITS;
  localparam int SW        = 142;
  localparam int R_SHIFT   = 2 * FRAC_BITS + 2;

  typedef struct packed {
    logic                  degen;
    logic                  neg;
    logic signed [SW-1:0]  p;
    logic signed [SW-1:0]  r;
    logic signed [SW-1:0]  a;
    logic signed [SW-1:0]  b;
    logic [Q_BITS-1:0]     q;
  } iter_t;

endpackage

>>> rtl/window_sums_to_ncc_top.sv
// Top level of the window-sum to normalized cross correlation pipeline.
// The slave channel takes one word of six window sums per cycle; the master
// channel gives one correlation word for each, in the same order.
// s_tdata fields from the lowest bit: sum_first[25:0], sum_second[51:26],
// sum_cross[93:52], sum_first_sq[135:94], sum_second_sq[177:136],
// sample_count[188:178], zero fill to 192 bits.
// m_tdata holds correlation in signed Q1.15; m_tuser is the degenerate flag,
// set with a zero correlation when either variance term is not positive.
// The pipeline has four front stages (products, differences, split
// partial products of the 53-bit variance and numerator terms, their sums),
// sixteen stages of the bitwise rounded quotient search, one output stage.
// Throughput is one word per cycle while the receiver does not stall.
// Every stage advances together while the output register is empty or taken;
// when the receiver stalls the whole pipeline holds and s_tready falls, so
// nothing is lost or repeated. Synchronous reset clears all valid bits.
module window_sums_to_ncc_top
  import wsncc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // sum_first, sum_second, sum_cross, sum_first_sq,
                                 // sum_second_sq, sample_count
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [15:0]  m_tdata,  // correlation
  output logic         m_tuser   // degenerate
);

  localparam int HB = 27;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [25:0] sa, sb;
  logic [41:0] sab, saa, sbb;
  logic [10:0] n;
  assign sa  = s_tdata[25:0];
  assign sb  = s_tdata[51:26];
  assign sab = s_tdata[93:52];
  assign saa = s_tdata[135:94];
  assign sbb = s_tdata[177:136];
  assign n   = s_tdata[188:178];

  logic v1, v2, v3, v4;
  logic [VAR_BITS-1:0] pa, qa, pb, qb, px, qx;
  logic [VAR_BITS-1:0] va, vb, mag;
  logic                degen2, neg2, degen3, neg3;
  logic [2*HB-1:0]     phh, phl, plh, pll, mhh, mhl, mll;

  logic [VAR_BITS-1:0] va_next, vb_next, mag_next;
  logic [PROD_BITS-1:0] p_sum, m_sum;
  iter_t                init_next, init_word;

  always_comb begin
    va_next  = pa - qa;
    vb_next  = pb - qb;
    mag_next = (px < qx) ? (qx - px) : (px - qx);
    p_sum = (PROD_BITS'(phh) << (2 * HB)) + (PROD_BITS'(phl) << HB)
          + (PROD_BITS'(plh) << HB) + PROD_BITS'(pll);
    m_sum = (PROD_BITS'(mhh) << (2 * HB)) + (PROD_BITS'(mhl) << (HB + 1))
          + PROD_BITS'(mll);
    init_next.degen = degen3;
    init_next.neg   = neg3;
    init_next.p     = $signed({{(SW - PROD_BITS){1'b0}}, p_sum});
    init_next.r     = $signed({{(SW - PROD_BITS){1'b0}}, m_sum}) <<< R_SHIFT;
    init_next.a     = init_next.p;
    init_next.b     = -init_next.p;
    init_next.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= VAR_BITS'(n) * VAR_BITS'(saa);
      qa <= VAR_BITS'(sa) * VAR_BITS'(sa);
      pb <= VAR_BITS'(n) * VAR_BITS'(sbb);
      qb <= VAR_BITS'(sb) * VAR_BITS'(sb);
      px <= VAR_BITS'(n) * VAR_BITS'(sab);
      qx <= VAR_BITS'(sa) * VAR_BITS'(sb);

      degen2 <= (pa <= qa) || (pb <= qb);
      neg2   <= (px < qx);
      va     <= va_next;
      vb     <= vb_next;
      mag    <= mag_next;

      degen3 <= degen2;
      neg3   <= neg2;
      phh <= (2*HB)'(va[VAR_BITS-1:HB]) * (2*HB)'(vb[VAR_BITS-1:HB]);
      phl <= (2*HB)'(va[VAR_BITS-1:HB]) * (2*HB)'(vb[HB-1:0]);
      plh <= (2*HB)'(va[HB-1:0]) * (2*HB)'(vb[VAR_BITS-1:HB]);
      pll <= (2*HB)'(va[HB-1:0]) * (2*HB)'(vb[HB-1:0]);
      mhh <= (2*HB)'(mag[VAR_BITS-1:HB]) * (2*HB)'(mag[VAR_BITS-1:HB]);
      mhl <= (2*HB)'(mag[VAR_BITS-1:HB]) * (2*HB)'(mag[HB-1:0]);
      mll <= (2*HB)'(mag[HB-1:0]) * (2*HB)'(mag[HB-1:0]);

      init_word <= init_next;
    end
  end

  logic  sv [Q_BITS+1];
  iter_t sw [Q_BITS+1];
  assign sv[0] = v4;
  assign sw[0] = init_word;

  for (genvar k = 0; k < Q_BITS; k++) begin : g_step
    wsncc_step #(.BIT(Q_BITS - 1 - k)) u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sv[k]),
      .in_word   (sw[k]),
      .out_valid (sv[k+1]),
      .out_word  (sw[k+1])
    );
  end

  iter_t       fin;
  logic [15:0] corr_next;
  assign fin = sw[Q_BITS];

  always_comb begin
    if (fin.degen) begin
      corr_next = '0;
    end else if (fin.neg) begin
      corr_next = (fin.q > 16'd32768) ? 16'h8000 : (16'd0 - fin.q);
    end else begin
      corr_next = (fin.q > 16'd32767) ? 16'h7FFF : fin.q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= sv[Q_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= corr_next;
      m_tuser <= fin.degen;
    end
  end

endmodule

>>> rtl/wsncc_step.sv
// One registered bit step of the rounded quotient search.
module wsncc_step
  import wsncc_pkg::*;
#(
  parameter int BIT = 15
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  iter_t in_word,
  output logic  out_valid,
  output iter_t out_word
);

  logic signed [SW-1:0] trial;
  logic                 take;
  iter_t                word_next;

  always_comb begin
    trial = in_word.a + (in_word.b <<< (BIT + 2)) + (in_word.p <<< (2 * BIT + 2));
    take  = (trial <= in_word.r);
    word_next = in_word;
    if (take) begin
      word_next.a      = trial;
      word_next.b      = in_word.b + (in_word.p <<< (BIT + 1));
      word_next.q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= word_next;
    end
  end

endmodule

>>> bench/tb_window_sums_to_ncc_top.sv
// Self-checking testbench for the window-sum normalized cross correlation pipeline.
`timescale 1ns / 100ps

module tb_window_sums_to_ncc_top;
  import wsncc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [25:0] sum_first;
    logic [25:0] sum_second;
    logic [41:0] sum_cross;
    logic [41:0] sum_first_sq;
    logic [41:0] sum_second_sq;
    logic [10:0] sample_count;
  } window_sums_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [15:0]  m_tdata;
  logic         m_tuser;

  logic [15:0] corr_expected_q[$];
  logic        degen_expected_q[$];
  int          errors;
  int          cycles;
  int          src_idle_pct;
  int          dst_stall_pct;
  bit          hold_request;
  int          hold_cycles;

  window_sums_to_ncc_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void ncc_predict(input window_sums_t w, output logic [15:0] corr,
                                      output logic degen);
    logic [255:0] n, pa, qa, pb, qb, px, qx, va, vb, mag, prod, rhs, lhs, d;
    logic [16:0] q, cand;
    bit neg;
    n  = 256'(w.sample_count);
    pa = n * w.sum_first_sq;
    qa = 256'(w.sum_first) * w.sum_first;
    pb = n * w.sum_second_sq;
    qb = 256'(w.sum_second) * w.sum_second;
    px = n * w.sum_cross;
    qx = 256'(w.sum_first) * w.sum_second;
    if (pa <= qa || pb <= qb) begin
      corr = '0;
      degen = 1'b1;
      return;
    end
    va = pa - qa;
    vb = pb - qb;
    neg = px < qx;
    mag = neg ? qx - px : px - qx;
    prod = va * vb;
    rhs = (mag * mag) << R_SHIFT;
    q = '0;
    for (int bitpos = 15; bitpos >= 0; bitpos--) begin
      cand = q | (17'd1 << bitpos);
      d = 2 * 256'(cand) - 1;
      lhs = d * d * prod;
      if (lhs <= rhs) q = cand;
    end
    if (neg) corr = (q > 17'd32768) ? 16'h8000 : 16'(-int'(q));
    else corr = (q > 17'd32767) ? 16'h7fff : q[15:0];
    degen = 1'b0;
  endfunction

  task automatic send_sums(input window_sums_t w);
    logic [15:0] corr;
    logic degen;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, w.sample_count, w.sum_second_sq, w.sum_first_sq,
                 w.sum_cross, w.sum_second, w.sum_first};
    do @(posedge clk); while (!s_tready);
    ncc_predict(w, corr, degen);
    corr_expected_q = {corr_expected_q, corr};
    degen_expected_q = {degen_expected_q, degen};
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  function automatic window_sums_t random_bits_sums();
    window_sums_t w;
    w.sum_first     = 26'($urandom);
    w.sum_second    = 26'($urandom);
    w.sum_cross     = 42'({$urandom, $urandom});
    w.sum_first_sq  = 42'({$urandom, $urandom});
    w.sum_second_sq = 42'({$urandom, $urandom});
    w.sample_count  = 11'($urandom);
    return w;
  endfunction

  // Accumulates a real window of pixel pairs with the relation selected by mode.
  function automatic window_sums_t pixel_window_sums(input int count, input int mode);
    window_sums_t w;
    logic [15:0] a, b, base;
    w = '{default: '0};
    w.sample_count = 11'(count);
    base = 16'($urandom);
    for (int k = 0; k < count; k++) begin
      a = 16'($urandom);
      case (mode)
        0: b = 16'($urandom);
        1: b = a;
        2: b = 16'hffff - a;
        3: b = 16'((a >> 1) + $urandom_range(0, 2000));
        4: begin
          a = base;
          b = 16'($urandom);
        end
        default: b = 16'(16'hffff - (a >> 2) + $urandom_range(0, 255));
      endcase
      w.sum_first     += 26'(a);
      w.sum_second    += 26'(b);
      w.sum_cross     += 42'(a) * 42'(b);
      w.sum_first_sq  += 42'(a) * 42'(a);
      w.sum_second_sq += 42'(b) * 42'(b);
    end
    return w;
  endfunction

  function automatic window_sums_t random_window();
    int count;
    count = ($urandom_range(19) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 24);
    if ($urandom_range(99) < 15) return random_bits_sums();
    return pixel_window_sums(count, $urandom_range(5));
  endfunction

  task automatic test_directed();
    window_sums_t w;
    src_idle_pct = 0;
    dst_stall_pct = 0;
    w = '{default: '0};
    send_sums(w);
    w = '{default: '1};
    send_sums(w);
    w = '{default: '1};
    w.sample_count = 11'd0;
    send_sums(w);
    w = '{default: '0};
    w.sample_count = 11'h7ff;
    w.sum_cross = '1;
    w.sum_first_sq = 42'd1;
    w.sum_second_sq = 42'd1;
    send_sums(w);
    w.sum_cross = 42'd0;
    w.sum_first = 26'd1;
    w.sum_second = '1;
    w.sum_first_sq = '1;
    w.sum_second_sq = '1;
    send_sums(w);
    w = '{sum_first: 26'd3, sum_second: 26'd3, sum_cross: 42'd9, sum_first_sq: 42'd9,
          sum_second_sq: 42'd9, sample_count: 11'd1};
    send_sums(w);
    for (int mode = 0; mode < 6; mode++) begin
      send_sums(pixel_window_sums(2, mode));
      send_sums(pixel_window_sums(1024, mode));
    end
    w = '{sum_first: 26'd0, sum_second: 26'd0, sum_cross: 42'd2, sum_first_sq: 42'd1,
          sum_second_sq: 42'd1, sample_count: 11'd2};
    send_sums(w);
    w.sum_first = 26'd2;
    w.sum_cross = 42'd0;
    w.sum_second = 26'd2;
    send_sums(w);
    w = '{sum_first: 26'd1, sum_second: 26'd1, sum_cross: 42'd1, sum_first_sq: 42'd1,
          sum_second_sq: 42'd2, sample_count: 11'd2};
    send_sums(w);
    for (int k = 0; k < 4; k++) send_sums(random_bits_sums());
    end_burst();
  endtask

  task automatic test_random_phase(input int src_pct, input int dst_pct, input int count);
    src_idle_pct = src_pct;
    dst_stall_pct = dst_pct;
    for (int k = 0; k < count; k++) send_sums(random_window());
    end_burst();
  endtask

  task automatic test_backpressure();
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_cycles = 300;
    hold_request = 1'b1;
    for (int k = 0; k < 120; k++) send_sums(random_window());
    end_burst();
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      m_tready <= 1'b0;
      if (hold_cycles > 0) hold_cycles--;
      else hold_request = 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (corr_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected word: corr=%h degen=%b", m_tdata, m_tuser);
      end else begin
        if (m_tdata !== corr_expected_q[0] || m_tuser !== degen_expected_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected corr=%h degen=%b, got corr=%h degen=%b",
                     corr_expected_q[0], degen_expected_q[0], m_tdata, m_tuser);
        end
        void'(corr_expected_q.pop_front());
        void'(degen_expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_request = 1'b0;
    hold_cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(0, 0, 450);
    test_random_phase(51, 0, 450);
    test_random_phase(0, 51, 450);
    test_random_phase(13, 13, 450);
    test_backpressure();
    dst_stall_pct = 0;
    while (corr_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
